// ===== rtl/blwm_pkg.sv =====
// Shared types, constants and helper functions of the beacon loss window monitor.
`default_nettype none
package blwm_pkg;

  localparam int WINDOW_DEPTH  = 64;
  localparam int IDX_W         = $clog2(WINDOW_DEPTH);
  localparam int CNT_W         = $clog2(WINDOW_DEPTH + 1);
  localparam int PERCENT_SCALE = 100;
  localparam int PROD_W        = $clog2(WINDOW_DEPTH * PERCENT_SCALE + 1);
  localparam int DCNT_W        = $clog2(PROD_W);
  localparam int HELD_W        = 7;
  localparam int CFG_W         = 48;

  localparam logic [11:0] MIN_FRAME_LEN      = 12'd24;
  localparam logic [15:0] TRACK_RESET        = 16'd10;
  localparam logic [3:0]  SUBTYPE_BEACON     = 4'h8;
  localparam logic [3:0]  SUBTYPE_PROBE_RESP = 4'h5;
  localparam logic [1:0]  TYPE_MGMT          = 2'b00;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    DROP_NONE     = 3'd0,
    DROP_SHORT    = 3'd1,
    DROP_NOT_MGMT = 3'd2,
    DROP_SUBTYPE  = 3'd3,
    DROP_BSSID    = 3'd4
  } drop_e;

  typedef enum logic {
    CFG_OWN_BSSID = 1'b0,
    CFG_TRACK     = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SPAN,
    ST_READ,
    ST_CHECK,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic span_load;
    logic trim_read;
    logic trim_pop;
    logic div_init;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic held_zero;
    logic entry_stale;
    logic div_last;
  } dp_stat_t;

  // Advance a ring index by one, wrapping at the window depth.
  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    if (a == IDX_W'(WINDOW_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = a + IDX_W'(1);
    end
    return r;
  endfunction

  // Ring index a + b, both below the depth.
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    logic [IDX_W:0] r;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W + 1)'(WINDOW_DEPTH)) begin
      r = s - (IDX_W + 1)'(WINDOW_DEPTH);
    end else begin
      r = s;
    end
    return r[IDX_W-1:0];
  endfunction

  function automatic logic [15:0] sat16(input logic [PROD_W-1:0] v);
    logic [15:0] r;
    if (32'(v) > 32'h0000_FFFF) begin
      r = 16'hFFFF;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/beacon_loss_window_monitor.sv =====
// Top level of the beacon loss window monitor: sequencer plus datapath.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+-----------
//  config   | cfg_we_i, cfg_index_i, cfg_wdata_i        | in
//  input    | in_valid_i / in_stall_o, frame fields     | in
//  result   | out_valid_o / out_stall_i, result fields  | out
//
// One item at a time: after accept it steps through update and span load, then reads
// and checks the oldest entry, dropping stale ones until one is fresh or none is left,
// then divider init, the divider steps and the output load. The trim reads use the
// ring memory's single read port. Reset clears control state, the window pointers,
// the start time, the last interval and the BSSID and presets the track count.
// A stalled result sits in the output register while the next item is worked on.
`default_nettype none
module beacon_loss_window_monitor (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire                          cfg_index_i,
  input  wire  [blwm_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [1:0]                   cmd_i,
  input  wire  [31:0]                  now_ms_i,
  input  wire  [11:0]                  frame_length_i,
  input  wire  [7:0]                   fc0_i,
  input  wire  [47:0]                  addr3_i,
  input  wire  [15:0]                  beacon_interval_field_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         accepted_o,
  output logic [2:0]                   drop_reason_o,
  output logic [15:0]                  reception_percent_o,
  output logic [blwm_pkg::HELD_W-1:0]  beacons_held_o
);

  blwm_pkg::dp_cmd_t  dp_cmd;
  blwm_pkg::dp_stat_t dp_stat;

  blwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  blwm_dp u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_index_i             (cfg_index_i),
    .cfg_wdata_i             (cfg_wdata_i),
    .cmd_i                   (cmd_i),
    .now_ms_i                (now_ms_i),
    .frame_length_i          (frame_length_i),
    .fc0_i                   (fc0_i),
    .addr3_i                 (addr3_i),
    .beacon_interval_field_i (beacon_interval_field_i),
    .cmd_i_s                 (dp_cmd),
    .stat_o                  (dp_stat),
    .accepted_o              (accepted_o),
    .drop_reason_o           (drop_reason_o),
    .reception_percent_o     (reception_percent_o),
    .beacons_held_o          (beacons_held_o)
  );

endmodule
`default_nettype wire

// ===== rtl/blwm_ctrl.sv =====
// Sequencer of the beacon loss window monitor: steps one item through update, trim and divide.
`default_nettype none
module blwm_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output blwm_pkg::dp_cmd_t   cmd_o,
  input  blwm_pkg::dp_stat_t  stat_i
);

  blwm_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blwm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      blwm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = blwm_pkg::ST_UPDATE;
        end
      end
      blwm_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = blwm_pkg::ST_SPAN;
      end
      blwm_pkg::ST_SPAN: begin
        cmd_o.span_load = 1'b1;
        state_d         = blwm_pkg::ST_READ;
      end
      blwm_pkg::ST_READ: begin
        if (stat_i.held_zero) begin
          state_d = blwm_pkg::ST_DIV_INIT;
        end else begin
          cmd_o.trim_read = 1'b1;
          state_d         = blwm_pkg::ST_CHECK;
        end
      end
      blwm_pkg::ST_CHECK: begin
        // drop the oldest entry and look at the next one, or stop trimming
        if (stat_i.entry_stale) begin
          cmd_o.trim_pop = 1'b1;
          state_d        = blwm_pkg::ST_READ;
        end else begin
          state_d = blwm_pkg::ST_DIV_INIT;
        end
      end
      blwm_pkg::ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = blwm_pkg::ST_DIV;
      end
      blwm_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = blwm_pkg::ST_DONE;
        end
      end
      blwm_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = blwm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = blwm_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != blwm_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/blwm_dp.sv =====
// Datapath of the beacon loss window monitor: filter, arrival ring, trim compare, divider.
`default_nettype none
module blwm_dp (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire                       cfg_index_i,
  input  wire  [blwm_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire  [1:0]                cmd_i,
  input  wire  [31:0]               now_ms_i,
  input  wire  [11:0]               frame_length_i,
  input  wire  [7:0]                fc0_i,
  input  wire  [47:0]               addr3_i,
  input  wire  [15:0]               beacon_interval_field_i,
  input  blwm_pkg::dp_cmd_t         cmd_i_s,
  output blwm_pkg::dp_stat_t        stat_o,
  output logic                      accepted_o,
  output logic [2:0]                drop_reason_o,
  output logic [15:0]               reception_percent_o,
  output logic [blwm_pkg::HELD_W-1:0] beacons_held_o
);

  localparam int IDX_W  = blwm_pkg::IDX_W;
  localparam int CNT_W  = blwm_pkg::CNT_W;
  localparam int PROD_W = blwm_pkg::PROD_W;
  localparam int DCNT_W = blwm_pkg::DCNT_W;

  // configuration
  logic [47:0] own_bssid_q;
  logic [15:0] track_q;

  // captured item
  logic [1:0]            icmd_q;
  logic [31:0]           now_q;
  logic [15:0]           bi_q;
  blwm_pkg::drop_e       reason_q, reason_d;

  // window state
  logic [31:0]      mem_q [blwm_pkg::WINDOW_DEPTH];
  logic [31:0]      rd_data_q;
  logic [IDX_W-1:0] oldest_q;
  logic [CNT_W-1:0] held_q;
  logic [31:0]      start_q;
  logic [15:0]      last_int_q;
  logic [31:0]      span_q;

  // divider
  logic [15:0]       den_q;
  logic [15:0]       rem_q;
  logic [PROD_W-1:0] quo_q;
  logic [DCNT_W-1:0] dcnt_q;

  logic              frame_ok;
  logic              full;
  logic [IDX_W-1:0]  wr_addr;
  logic [31:0]       elapsed;
  logic [15:0]       expected;
  logic [16:0]       rem_sh;
  logic              q_bit;
  logic [16:0]       rem_next;

  // frame filter, checks in priority order
  always_comb begin
    priority if (frame_length_i < blwm_pkg::MIN_FRAME_LEN) begin
      reason_d = blwm_pkg::DROP_SHORT;
    end else if (fc0_i[3:2] != blwm_pkg::TYPE_MGMT) begin
      reason_d = blwm_pkg::DROP_NOT_MGMT;
    end else if (fc0_i[7:4] != blwm_pkg::SUBTYPE_BEACON &&
                 fc0_i[7:4] != blwm_pkg::SUBTYPE_PROBE_RESP) begin
      reason_d = blwm_pkg::DROP_SUBTYPE;
    end else if (addr3_i != own_bssid_q) begin
      reason_d = blwm_pkg::DROP_BSSID;
    end else begin
      reason_d = blwm_pkg::DROP_NONE;
    end
  end

  assign frame_ok = (icmd_q == blwm_pkg::CMD_FRAME) && (reason_q == blwm_pkg::DROP_NONE);
  assign full     = (held_q >= CNT_W'(blwm_pkg::WINDOW_DEPTH));
  assign wr_addr  = full ? oldest_q : blwm_pkg::slot_add(oldest_q, held_q[IDX_W-1:0]);

  assign elapsed  = now_q - start_q;
  assign expected = (elapsed < 32'(track_q)) ? elapsed[15:0] : track_q;

  // restoring division, one quotient bit per step
  assign rem_sh   = {rem_q, quo_q[PROD_W-1]};
  assign q_bit    = (rem_sh >= {1'b0, den_q});
  assign rem_next = q_bit ? (rem_sh - {1'b0, den_q}) : rem_sh;

  assign stat_o.held_zero   = (held_q == '0);
  assign stat_o.entry_stale = ((now_q - rd_data_q) > span_q);
  assign stat_o.div_last    = (dcnt_q == DCNT_W'(PROD_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_bssid_q <= '0;
      track_q     <= blwm_pkg::TRACK_RESET;
    end else if (cfg_we_i) begin
      unique case (blwm_pkg::cfg_idx_e'(cfg_index_i))
        blwm_pkg::CFG_OWN_BSSID: own_bssid_q <= cfg_wdata_i[47:0];
        blwm_pkg::CFG_TRACK:     track_q     <= cfg_wdata_i[15:0];
        default:                 track_q     <= track_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q   <= '0;
      held_q     <= '0;
      start_q    <= '0;
      last_int_q <= '0;
    end else if (cmd_i_s.update) begin
      if (frame_ok) begin
        last_int_q <= bi_q;
        if (full) begin
          oldest_q <= blwm_pkg::slot_inc(oldest_q);
        end else begin
          held_q <= held_q + CNT_W'(1);
        end
      end else if (icmd_q == blwm_pkg::CMD_CLEAR) begin
        start_q  <= now_q;
        held_q   <= '0;
        oldest_q <= '0;
      end
    end else if (cmd_i_s.trim_pop) begin
      oldest_q <= blwm_pkg::slot_inc(oldest_q);
      held_q   <= held_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i_s.update && frame_ok) begin
      mem_q[wr_addr] <= now_q;
    end
    if (cmd_i_s.trim_read) begin
      rd_data_q <= mem_q[oldest_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i_s.capture) begin
      icmd_q   <= cmd_i;
      now_q    <= now_ms_i;
      bi_q     <= beacon_interval_field_i;
      reason_q <= reason_d;
    end
    if (cmd_i_s.span_load) begin
      span_q <= 32'(track_q) * 32'(last_int_q);
    end
    if (cmd_i_s.div_init) begin
      den_q  <= expected;
      rem_q  <= '0;
      quo_q  <= PROD_W'(held_q) * PROD_W'(blwm_pkg::PERCENT_SCALE);
      dcnt_q <= '0;
    end else if (cmd_i_s.div_step) begin
      rem_q  <= rem_next[15:0];
      quo_q  <= {quo_q[PROD_W-2:0], q_bit};
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
    if (cmd_i_s.out_load) begin
      accepted_o          <= frame_ok;
      drop_reason_o       <= (icmd_q == blwm_pkg::CMD_FRAME) ? reason_q : blwm_pkg::DROP_NONE;
      reception_percent_o <= (den_q == '0) ? 16'd0 : blwm_pkg::sat16(quo_q);
      beacons_held_o      <= blwm_pkg::HELD_W'(held_q);
    end
  end

endmodule
`default_nettype wire
